// ===== hdl/acyclic_dependency_graph_engine_macros.svh =====
// Assertion macros shared by the checker of the dependency graph engine.
// No dependencies; included by files that assert.
`ifndef ACYCLIC_DEPENDENCY_GRAPH_ENGINE_MACROS_SVH
`define ACYCLIC_DEPENDENCY_GRAPH_ENGINE_MACROS_SVH

// same-cycle implication
`define ADGE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/adge_pkg.sv =====
// Shared types and codes of the dependency graph engine.
// No dependencies; imported by adge_edge_store, adge_seq and the top level.
`default_nettype none
package adge_pkg;

	localparam int NODE_W    = 5;
	localparam int MAX_NODES = 32;
	localparam int MASK_W    = 32;

	localparam logic [1:0] ACT_EDGE  = 2'd0;
	localparam logic [1:0] ACT_MARK  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_IGNORED = 2'd1;
	localparam logic [1:0] STS_EXISTS  = 2'd2;
	localparam logic [1:0] STS_CYCLE   = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] reader_node;
		logic              source_is_none;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [MASK_W-1:0] dirty_mask;
	} out_word_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] row;
		logic [NODE_W-1:0] col;
	} edge_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SEED,
		ST_SWEEP
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/adge_edge_store.sv =====
// Adjacency matrix of the graph and the shared row-gather unit (OR of selected rows).
// Depends on adge_pkg.
`default_nettype none
module adge_edge_store #(
	parameter int NODES = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  adge_pkg::edge_wr_t      wr,
	input  logic [NODES-1:0]        gather_sel,
	output logic [NODES-1:0]        gather_data
);
	import adge_pkg::*;

	logic [NODES-1:0] rows_q [NODES];
	logic [NODES-1:0] col_bit;

	assign col_bit = NODES'(1) << wr.col;

	for (genvar g = 0; g < NODES; g++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rows_q[g] <= '0;
			end else if (wr.we && wr.row == NODE_W'(g)) begin
				rows_q[g] <= rows_q[g] | col_bit;
			end
		end
	end

	always_comb begin
		gather_data = '0;
		for (int i = 0; i < NODES; i++) begin
			if (gather_sel[i]) begin
				gather_data = gather_data | rows_q[i];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/adge_seq.sv =====
// Sequencer: decodes a command word, runs the reachability sweep on the row-gather
// unit, keeps dirty bits and the present mask. Depends on adge_pkg.
`default_nettype none
module adge_seq #(
	parameter int NODES = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  adge_pkg::in_word_t      cmd,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_wdata,
	output logic                    done,
	output adge_pkg::out_word_t     result,
	output adge_pkg::edge_wr_t      wr,
	output logic [NODES-1:0]        gather_sel,
	input  logic [NODES-1:0]        gather_data
);
	import adge_pkg::*;

	localparam int STEP_W = $clog2(NODES + 1);

	state_t            state_q, state_d;
	in_word_t          cmd_q;
	logic [31:0]       present_q;
	logic [NODES-1:0]  dirty_q, dirty_d;
	logic [NODES-1:0]  seen_q, seen_d;
	logic [NODES-1:0]  front_q, front_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              done_q, done_d;
	out_word_t         result_q, result_d;

	logic [NODES-1:0]  src_bit, rdr_bit, fresh;
	logic              src_in, rdr_in, src_ok, ignore;

	assign src_bit = NODES'(1) << cmd_q.source_node;
	assign rdr_bit = NODES'(1) << cmd_q.reader_node;
	assign src_in  = {1'b0, cmd_q.source_node} < (NODE_W+1)'(NODES);
	assign rdr_in  = {1'b0, cmd_q.reader_node} < (NODE_W+1)'(NODES);
	assign src_ok  = !cmd_q.source_is_none && src_in;
	assign ignore  = cmd_q.source_is_none || !src_in || !rdr_in
		|| cmd_q.source_node == cmd_q.reader_node;
	assign fresh   = gather_data & ~seen_q;

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dirty_q   <= '0;
			present_q <= '1;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			dirty_q <= dirty_d;
			done_q  <= done_d;
			if (cfg_we) begin
				present_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		seen_q   <= seen_d;
		front_q  <= front_d;
		step_q   <= step_d;
		result_q <= result_d;
	end

	always_comb begin
		state_d    = state_q;
		dirty_d    = dirty_q;
		seen_d     = seen_q;
		front_d    = front_q;
		step_d     = step_q;
		done_d     = 1'b0;
		result_d   = result_q;
		gather_sel = '0;
		wr         = '0;
		wr.row     = cmd_q.source_node;
		wr.col     = cmd_q.reader_node;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				gather_sel      = src_bit;
				done_d          = 1'b1;
				state_d         = ST_IDLE;
				result_d.status = STS_OK;
				unique case (cmd_q.action)
					ACT_EDGE: begin
						if (ignore) begin
							result_d.status = STS_IGNORED;
						end else if (|(gather_data & rdr_bit)) begin
							result_d.status = STS_EXISTS;
						end else begin
							done_d  = 1'b0;
							state_d = ST_SEED;
						end
					end
					ACT_MARK: begin
						if (src_ok) begin
							dirty_d = dirty_q | (gather_data & present_q[NODES-1:0]);
						end
					end
					ACT_CLEAR: begin
						if (src_ok) begin
							dirty_d = dirty_q & ~src_bit;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SEED: begin
				gather_sel = rdr_bit;
				seen_d     = gather_data;
				front_d    = gather_data;
				step_d     = '0;
				state_d    = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (|(seen_q & src_bit)) begin
					result_d.status = STS_CYCLE;
					done_d          = 1'b1;
					state_d         = ST_IDLE;
				end else if (front_q == '0 || step_q == STEP_W'(NODES)) begin
					wr.we           = 1'b1;
					result_d.status = STS_OK;
					done_d          = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					gather_sel = front_q;
					seen_d     = seen_q | fresh;
					front_d    = fresh;
					step_d     = step_q + STEP_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		result_d.dirty_mask = MASK_W'(dirty_d);
	end

endmodule
`default_nettype wire

// ===== hdl/acyclic_dependency_graph_engine.sv =====
// Top level of the acyclic dependency graph engine.
// Depends on adge_pkg, adge_edge_store and adge_seq.
//
// Command channel: cmd is taken at a clock edge where start is high and busy is
// low. Actions: register an edge source->reader (rejected if it would close a
// cycle), mark the present direct readers of a source dirty, clear the dirty
// bit of a source.
// Result channel: done pulses for one cycle with result (status, dirty mask
// after the command). The receiver cannot stall; each word is shown once.
// Mark, clear, ignored and existing-edge commands end in the evaluate state.
// A new edge then passes the seed state and a reachability sweep of at most
// NODES frontier steps (NODES being the node count capped at 32); each step is
// one pass of the shared row-gather unit over the adjacency rows.
// busy is high from the accept edge until the cycle done shows; a new command
// may be taken in that cycle.
// Configuration: cfg_we/cfg_wdata write the present mask. The user must write
// it only while idle; the block itself does not enforce this.
// Reset (arst_n low): no edges, no dirty bits, present mask all ones.
`default_nettype none
module acyclic_dependency_graph_engine #(
	parameter int NODE_COUNT = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  adge_pkg::in_word_t   cmd,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	output logic                 done,
	output adge_pkg::out_word_t  result
);
	import adge_pkg::*;

	localparam int NODES = (NODE_COUNT < MAX_NODES) ? NODE_COUNT : MAX_NODES;

	edge_wr_t         wr;
	logic [NODES-1:0] gather_sel;
	logic [NODES-1:0] gather_data;

	adge_seq #(
		.NODES(NODES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.result     (result),
		.wr         (wr),
		.gather_sel (gather_sel),
		.gather_data(gather_data)
	);

	adge_edge_store #(
		.NODES(NODES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.gather_sel (gather_sel),
		.gather_data(gather_data)
	);

endmodule
`default_nettype wire

// ===== hdl/adge_checker.sv =====
// Port-level checker of the dependency graph engine, bound to the top level.
// Depends on acyclic_dependency_graph_engine_macros.svh.
`default_nettype none
`include "acyclic_dependency_graph_engine_macros.svh"
module adge_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	`ADGE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "not busy after accept")
	`ADGE_ASSERT_NEXT(a_no_instant, clk, arst_n, start && !busy, !done, "done right after accept")
	`ADGE_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "busy while done")
	`ADGE_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "done held two cycles")
endmodule

bind acyclic_dependency_graph_engine adge_checker u_adge_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
`default_nettype wire
